// ===== rtl/assert_macros.svh =====
// assertion macros used by damped_zoom_animator
// each macro takes a label, the clock, the active-low reset and the property terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DZA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("dza assertion failed");
`define DZA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("dza assertion failed");
`else
`define DZA_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define DZA_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/dza_pkg.sv =====
// ----------------------------------------------------------------------------
// dza_pkg
// Types, constants and codes of the damped zoom animator.
// ----------------------------------------------------------------------------
package dza_pkg;

  // serial unit widths
  localparam int MUL_W  = 32;
  localparam int MUL_CW = $clog2(MUL_W);
  localparam int DIV_W  = 64;
  localparam int DVS_W  = 32;
  localparam int DIV_CW = $clog2(DIV_W);

  // q16 constants
  localparam logic [22:0] ONE_Q    = 23'd65536;
  localparam logic [22:0] ZMAX_Q   = 23'd4194304;
  localparam logic [14:0] HALF_Q   = 15'd32767;
  localparam logic [13:0] K_015    = 14'd9830;
  localparam logic [17:0] K_020    = 18'd13107;
  localparam logic [17:0] A_MAX    = 18'd131072;
  localparam logic [7:0]  K_0002   = 8'd131;
  localparam logic [8:0]  K_0004   = 9'd262;
  localparam logic [9:0]  K_001    = 10'd655;
  localparam logic [14:0] K_035    = 15'd22938;
  localparam logic [4:0]  MAX_STEPS = 5'd16;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_ZIN   = 3'd3,
    OP_ZOUT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_SPEED  = 2'd0,
    CFG_TSTEP  = 2'd1,
    CFG_PRESET = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ZDIV,
    ST_T_MUL1,
    ST_T_MUL2,
    ST_T_STEPS,
    ST_T_CHUNK,
    ST_S_BEGIN,
    ST_S_ADJ,
    ST_S_AV,
    ST_S_DIV,
    ST_S_CHK,
    ST_S_CHG,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  elapsed_ms;
    logic [22:0] requested_factor_q16;
  } in_item_t;

  typedef struct packed {
    logic [22:0] zoom_q16;
    logic [22:0] target_q16;
    logic        animating;
    logic        magnifying;
    logic [16:0] frame_alpha_q16;
  } out_item_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/dza_mul.sv =====
// ----------------------------------------------------------------------------
// dza_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dza_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dza_pkg::MUL_W-1:0]     mul_a,
  input  logic [dza_pkg::MUL_W-1:0]     mul_b,
  output logic [2*dza_pkg::MUL_W-1:0]   prod,
  output dza_pkg::unit_stat_t           stat
);
  import dza_pkg::*;

  logic [2*MUL_W-1:0] acc_r;
  logic [2*MUL_W-1:0] mcand_r;
  logic [MUL_W-1:0]   mplier_r;
  logic [MUL_CW-1:0]  cnt_r;
  logic               busy_r;
  logic               done_r;

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CW'(MUL_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // accumulate shifted multiplicand
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= {{MUL_W{1'b0}}, mul_a};
      mplier_r <= mul_b;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[2*MUL_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[MUL_W-1:1]};
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/dza_div.sv =====
// ----------------------------------------------------------------------------
// dza_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dza_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dza_pkg::DIV_W-1:0] dividend,
  input  logic [dza_pkg::DVS_W-1:0] divisor,
  output logic [dza_pkg::DIV_W-1:0] quot,
  output dza_pkg::unit_stat_t       stat
);
  import dza_pkg::*;

  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  // trial subtract
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift dividend out, quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign quot      = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/damped_zoom_animator.sv =====
// ----------------------------------------------------------------------------
// damped_zoom_animator
// Damped zoom animation: command and tick transactions update zoom, target,
// velocity and animating flag through a serial multiplier and divider.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall  | in_item_t (operation, elapsed, factor)
//  out_     | output    | out_valid/out_stall| out_item_t (zoom, target, flags, alpha)
//  cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
//  start, stop and unused codes go straight to the result, zoom in/out runs one divide
//  a tick runs two multiplies and one or two divides, plus up to 16 sub-steps,
//  all on the serial multiplier and the serial divider
//  one transaction is in work at a time; the output register frees the input
//  reset is synchronous: zoom and target 1.0, velocity 0, not animating
//  a stalled result holds the next one in the final state until taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module damped_zoom_animator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dza_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dza_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [22:0]         cfg_wdata
);
  import dza_pkg::*;

  state_t      state_r;
  state_t      state_nxt;
  in_item_t    item_r;
  logic [11:0] speed_r;
  logic [11:0] tstep_r;
  logic [22:0] preset_r;
  logic [22:0] zoom_r;
  logic [22:0] goal_r;
  logic [23:0] vel_r;
  logic        moving_r;
  logic [36:0] prod_r;
  logic [4:0]  steps_r;
  logic [4:0]  left_r;
  logic [28:0] chunk_r;
  logic [19:0] adj_r;
  logic        num_neg_r;
  logic        out_valid_r;
  out_item_t   out_r;

  // serial unit hookup
  logic                 mul_start;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  unit_stat_t           mul_stat;
  logic                 div_start;
  logic [DIV_W-1:0]     div_n;
  logic [DVS_W-1:0]     div_d;
  logic [DIV_W-1:0]     div_q;
  unit_stat_t           div_stat;

  // derived values
  logic        in_acc;
  logic        out_free;
  logic [23:0] dx;
  logic [23:0] dx_abs;
  logic        dx_neg;
  logic        dx_pos;
  logic [22:0] dx_mag;
  logic [24:0] a_raw;
  logic [17:0] a_q;
  logic [23:0] vel_abs;
  logic        vel_neg;
  logic [22:0] vel_mag;
  logic [43:0] nv;
  logic [43:0] na;
  logic [43:0] num;
  logic [43:0] num_abs;
  logic [42:0] num_mag;
  logic [23:0] vel_new;
  logic        settle;
  logic [35:0] chg_mag;
  logic [39:0] change;
  logic [39:0] zsum;
  logic [22:0] zoom_new;
  logic [4:0]  steps_sat;
  logic [22:0] start_req;
  logic [22:0] start_goal;
  logic [22:0] excess;
  logic [16:0] alpha;

  dza_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (mul_p),
    .stat  (mul_stat)
  );

  dza_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quot     (div_q),
    .stat     (div_stat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sub-step arithmetic
  always_comb begin
    dx      = {1'b0, goal_r} - {1'b0, zoom_r};
    dx_neg  = dx[23];
    dx_abs  = dx_neg ? (~dx + 24'd1) : dx;
    dx_mag  = dx_abs[22:0];
    dx_pos  = !dx_neg && (dx != '0);
    a_raw   = ({2'b0, dx_mag} + {1'b0, dx_mag, 1'b0}) >> 1;
    if (a_raw < {7'b0, K_020}) begin
      a_q = K_020;
    end else if (a_raw > {7'b0, A_MAX}) begin
      a_q = A_MAX;
    end else begin
      a_q = a_raw[17:0];
    end
    vel_neg = vel_r[23];
    vel_abs = vel_neg ? (~vel_r + 24'd1) : vel_r;
    vel_mag = vel_abs[22:0];
    nv      = vel_neg ? (~{3'b0, mul_p[40:0]} + 44'd1) : {3'b0, mul_p[40:0]};
    na      = dx_neg ? (~{8'b0, adj_r, 16'b0} + 44'd1) : {8'b0, adj_r, 16'b0};
    num     = nv + na;
    num_abs = num[43] ? (~num + 44'd1) : num;
    num_mag = num_abs[42:0];
    vel_new = num_neg_r ? (~{1'b0, div_q[22:0]} + 24'd1) : {1'b0, div_q[22:0]};
    settle  = (dx_mag < {15'b0, K_0002}) && (vel_mag < {14'b0, K_0004});
    chg_mag = mul_p[51:16];
    if ((chg_mag == '0) && (vel_r != '0)) begin
      change = dx_pos ? {30'b0, K_001} : (~{30'b0, K_001} + 40'd1);
    end else begin
      change = vel_neg ? (~{4'b0, chg_mag} + 40'd1) : {4'b0, chg_mag};
    end
    zsum = {17'b0, zoom_r} + change;
    if ($signed(zsum) < $signed({17'b0, ONE_Q})) begin
      zoom_new = ONE_Q;
    end else if ($signed(zsum) > $signed({17'b0, ZMAX_Q})) begin
      zoom_new = ZMAX_Q;
    end else begin
      zoom_new = zsum[22:0];
    end
  end

  // tick and command arithmetic
  always_comb begin
    if (div_q == '0) begin
      steps_sat = 5'd1;
    end else if (div_q > DIV_W'(MAX_STEPS)) begin
      steps_sat = MAX_STEPS;
    end else begin
      steps_sat = div_q[4:0];
    end
    start_req = (item_r.requested_factor_q16 == ONE_Q) ? ONE_Q : preset_r;
    if ((item_r.requested_factor_q16 == '0) && (goal_r != ONE_Q)) begin
      start_goal = ONE_Q;
    end else if (start_req < ONE_Q) begin
      start_goal = ONE_Q;
    end else if (start_req > ZMAX_Q) begin
      start_goal = ZMAX_Q;
    end else begin
      start_goal = start_req;
    end
    excess = zoom_r - ONE_Q;
    alpha  = (excess > {8'b0, HALF_Q}) ? 17'd65536 : {1'b0, excess[14:0], 1'b0};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_DECODE;
      ST_DECODE: begin
        unique case (item_r.operation)
          OP_TICK:         state_nxt = moving_r ? ST_T_MUL1 : ST_RESULT;
          OP_ZIN, OP_ZOUT: state_nxt = ST_ZDIV;
          default:         state_nxt = ST_RESULT;
        endcase
      end
      ST_ZDIV:    if (div_stat.done) state_nxt = ST_RESULT;
      ST_T_MUL1:  if (mul_stat.done) state_nxt = ST_T_MUL2;
      ST_T_MUL2: begin
        if (mul_stat.done) state_nxt = (tstep_r != '0) ? ST_T_STEPS : ST_T_CHUNK;
      end
      ST_T_STEPS: if (div_stat.done) state_nxt = ST_T_CHUNK;
      ST_T_CHUNK: if (div_stat.done) state_nxt = ST_S_BEGIN;
      ST_S_BEGIN: state_nxt = ST_S_ADJ;
      ST_S_ADJ:   if (mul_stat.done) state_nxt = ST_S_AV;
      ST_S_AV:    if (mul_stat.done) state_nxt = ST_S_DIV;
      ST_S_DIV:   if (div_stat.done) state_nxt = ST_S_CHK;
      ST_S_CHK:   state_nxt = settle ? ST_RESULT : ST_S_CHG;
      ST_S_CHG: begin
        if (mul_stat.done) state_nxt = (left_r == 5'd1) ? ST_RESULT : ST_S_BEGIN;
      end
      ST_RESULT:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // unit starts and operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_r)
      ST_DECODE: begin
        unique case (item_r.operation)
          OP_TICK: begin
            mul_start = moving_r;
            mul_a     = MUL_W'(item_r.elapsed_ms);
            mul_b     = MUL_W'(speed_r);
          end
          OP_ZIN: begin
            div_start = 1'b1;
            div_n     = DIV_W'({goal_r, 2'b00}) + DIV_W'({goal_r, 1'b0});
            div_d     = DVS_W'(5);
          end
          OP_ZOUT: begin
            div_start = 1'b1;
            div_n     = DIV_W'({goal_r, 2'b00}) + DIV_W'(goal_r);
            div_d     = DVS_W'(6);
          end
          default: ;
        endcase
      end
      ST_T_MUL1: begin
        mul_start = mul_stat.done;
        mul_a     = MUL_W'(mul_p[21:0]);
        mul_b     = MUL_W'(K_035);
      end
      ST_T_MUL2: begin
        div_start = mul_stat.done;
        if (tstep_r != '0) begin
          div_n = DIV_W'(mul_p[36:0]);
          div_d = DVS_W'({tstep_r, 15'd0});
        end else begin
          div_n = DIV_W'(mul_p[36:8]);
          div_d = DVS_W'(MAX_STEPS);
        end
      end
      ST_T_STEPS: begin
        div_start = div_stat.done;
        div_n     = DIV_W'(prod_r[36:8]);
        div_d     = DVS_W'(steps_sat);
      end
      ST_S_BEGIN: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(dx_mag);
        mul_b     = MUL_W'(K_015);
      end
      ST_S_ADJ: begin
        mul_start = mul_stat.done;
        mul_a     = MUL_W'(a_q);
        mul_b     = MUL_W'(vel_mag);
      end
      ST_S_AV: begin
        div_start = mul_stat.done;
        div_n     = DIV_W'(num_mag);
        div_d     = DVS_W'({1'b0, a_q} + 19'd65536);
      end
      ST_S_CHK: begin
        mul_start = !settle;
        mul_a     = MUL_W'(vel_mag);
        mul_b     = MUL_W'(chunk_r);
      end
      default: ;
    endcase
  end

  // state, animation state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      speed_r     <= 12'd256;
      tstep_r     <= 12'd384;
      preset_r    <= 23'd131072;
      zoom_r      <= ONE_Q;
      goal_r      <= ONE_Q;
      vel_r       <= '0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SPEED:  speed_r  <= cfg_wdata[11:0];
          CFG_TSTEP:  tstep_r  <= cfg_wdata[11:0];
          CFG_PRESET: preset_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == ST_DECODE) && (item_r.operation == OP_START)) begin
        goal_r   <= start_goal;
        moving_r <= 1'b1;
      end
      if ((state_r == ST_DECODE) && (item_r.operation == OP_STOP)) begin
        goal_r   <= ONE_Q;
        moving_r <= 1'b1;
      end
      if ((state_r == ST_ZDIV) && div_stat.done) begin
        moving_r <= 1'b1;
        if (item_r.operation == OP_ZIN) begin
          goal_r <= (div_q > DIV_W'(ZMAX_Q)) ? ZMAX_Q : div_q[22:0];
        end else begin
          goal_r <= (div_q < DIV_W'(ONE_Q)) ? ONE_Q : div_q[22:0];
        end
      end
      if ((state_r == ST_S_DIV) && div_stat.done) begin
        vel_r <= vel_new;
      end
      if ((state_r == ST_S_CHK) && settle) begin
        vel_r    <= '0;
        zoom_r   <= goal_r;
        moving_r <= 1'b0;
      end
      if ((state_r == ST_S_CHG) && mul_stat.done) begin
        zoom_r <= zoom_new;
      end
      // output register
      if ((state_r == ST_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if ((state_r == ST_T_MUL2) && mul_stat.done) begin
      prod_r  <= mul_p[36:0];
      steps_r <= MAX_STEPS;
    end
    if ((state_r == ST_T_STEPS) && div_stat.done) begin
      steps_r <= steps_sat;
    end
    if ((state_r == ST_T_CHUNK) && div_stat.done) begin
      chunk_r <= div_q[28:0];
      left_r  <= steps_r;
    end
    if ((state_r == ST_S_ADJ) && mul_stat.done) begin
      adj_r <= mul_p[35:16];
    end
    if ((state_r == ST_S_AV) && mul_stat.done) begin
      num_neg_r <= num[43];
    end
    if ((state_r == ST_S_CHG) && mul_stat.done) begin
      left_r <= left_r - 5'd1;
    end
    if ((state_r == ST_RESULT) && out_free) begin
      out_r.zoom_q16        <= zoom_r;
      out_r.target_q16      <= goal_r;
      out_r.animating       <= moving_r;
      out_r.magnifying      <= (zoom_r != ONE_Q);
      out_r.frame_alpha_q16 <= alpha;
    end
  end

  // checks
  `DZA_ASSERT_IMP(a_mul_free, clk, rst_n, mul_start, !mul_stat.busy)
  `DZA_ASSERT_IMP(a_div_free, clk, rst_n, div_start, !div_stat.busy)
  `DZA_ASSERT_IMP(a_zoom_rng, clk, rst_n, 1'b1, (zoom_r >= ONE_Q) && (zoom_r <= ZMAX_Q))
  `DZA_ASSERT_NXT(a_settle, clk, rst_n, (state_r == ST_S_CHK) && settle, !moving_r && (vel_r == '0))

endmodule
